// ===== rtl/core/hbs_pkg.sv =====
// -----------------------------------------------------------------------------
// hbs_pkg: shared types and constants of the heightmap bilinear sampler
// Request and result structs, register indexes, opcodes, fixed field widths.
// -----------------------------------------------------------------------------
`default_nettype none

package hbs_pkg;

  // fixed-point format of positions and heights
  localparam int FRAC_BITS = 8;
  localparam int POS_W     = 23;
  localparam int INT_W     = POS_W - FRAC_BITS;
  localparam int COORD_W   = 7;
  localparam int HGT_W     = 16;
  localparam int OUT_W     = 24;
  localparam int SCALE_W   = 8;
  localparam int MAXC_W    = 7;
  localparam int CFG_W     = 8;

  localparam logic [SCALE_W-1:0] CELL_SCALE_RST = 8'd10;
  localparam logic [MAXC_W-1:0]  MAX_CELL_RST   = 7'd100;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    CFG_CELL_SCALE = 1'b0,
    CFG_MAX_CELL   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t                      op;
    logic [COORD_W-1:0]       grid_col;
    logic [COORD_W-1:0]       grid_row;
    logic signed [HGT_W-1:0]  sample_height;
    logic [POS_W-1:0]         query_x;
    logic [POS_W-1:0]         query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0]  height_out;
    logic                     out_of_range;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/hbs_ram.sv =====
// -----------------------------------------------------------------------------
// hbs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/heightmap_bilinear_sampler.sv =====
// -----------------------------------------------------------------------------
// heightmap_bilinear_sampler: bilinear height lookup over a banked sample grid
// Pipeline: a query passes the request register, front divider, bank read, weights,
//   products, adder tree, magnitude, back divider and output register to out_strobe.
// Throughput: one request per cycle while busy is low, writes and queries mixed freely; set by
//   the bit-per-stage dividers and the four-bank grid RAM (one read per bank).
// Reset: synchronous, clears the valid pipeline and loads register defaults;
//   busy is high only while rst_n is low. Grid contents are not cleared.
// -----------------------------------------------------------------------------
`default_nettype none

module heightmap_bilinear_sampler #(
  parameter int GRID_DIM = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // request channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire hbs_pkg::in_item_t           in_item,
  // result channel, no back-pressure
  output logic                             out_strobe,
  output hbs_pkg::out_item_t               out_item,
  // register write port
  input  wire logic                        cfg_we,
  input  wire hbs_pkg::cfg_idx_t           cfg_index,
  input  wire logic [hbs_pkg::CFG_W-1:0]   cfg_wdata
);

  // Grid is split into four banks by column and row parity, so the four
  // corners of any cell land in four different banks.
  localparam int EFF_DIM    = (GRID_DIM < 128) ? GRID_DIM : 128;
  localparam int HALF       = (EFF_DIM + 1) / 2;
  localparam int BANK_DEPTH = (HALF * HALF < 2) ? 2 : HALF * HALF;
  localparam int BAW        = $clog2(BANK_DEPTH);

  // pipeline depth: front divide 8, bank read 1, weights 1, products 1,
  // adder tree 2, magnitude 1, back divide 24, output 1
  localparam int FDIV_N = 7;
  localparam int QDIV_N = 24;
  localparam int LAT    = 1 + FDIV_N + 1 + 1 + 1 + 2 + 1 + QDIV_N + 1;

  // ---------------------------------------------------------------------------
  // Registers and values derived from them
  // ---------------------------------------------------------------------------
  logic [hbs_pkg::SCALE_W-1:0] scale_r;
  logic [hbs_pkg::MAXC_W-1:0]  maxc_r;
  logic [hbs_pkg::POS_W-1:0]   limit_r;   // max_cell * spacing, position units
  logic [23:0]                 dvs_r;     // spacing squared << FRAC_BITS

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= hbs_pkg::CELL_SCALE_RST;
      maxc_r  <= hbs_pkg::MAX_CELL_RST;
      limit_r <= {15'(16'(hbs_pkg::MAX_CELL_RST) * 16'(hbs_pkg::CELL_SCALE_RST)),
                  {hbs_pkg::FRAC_BITS{1'b0}}};
      dvs_r   <= {16'(16'(hbs_pkg::CELL_SCALE_RST) * 16'(hbs_pkg::CELL_SCALE_RST)),
                  {hbs_pkg::FRAC_BITS{1'b0}}};
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          hbs_pkg::CFG_CELL_SCALE: scale_r <= cfg_wdata;
          hbs_pkg::CFG_MAX_CELL:   maxc_r  <= cfg_wdata[hbs_pkg::MAXC_W-1:0];
          default: ;
        endcase
      end
      limit_r <= {15'(16'(maxc_r) * 16'(scale_r)), {hbs_pkg::FRAC_BITS{1'b0}}};
      dvs_r   <= {16'(16'(scale_r) * 16'(scale_r)), {hbs_pkg::FRAC_BITS{1'b0}}};
    end
  end

  assign busy = ~rst_n;

  // ---------------------------------------------------------------------------
  // Front: cell index = integer position / spacing, one quotient bit a stage.
  // Index 0 is the request register. Writes ride along so that grid updates
  // stay in order with the bank reads of earlier queries.
  // ---------------------------------------------------------------------------
  logic                        fv_r   [0:FDIV_N];
  hbs_pkg::op_t                fop_r  [0:FDIV_N];
  logic [hbs_pkg::COORD_W-1:0] fcol_r [0:FDIV_N];
  logic [hbs_pkg::COORD_W-1:0] frow_r [0:FDIV_N];
  logic [hbs_pkg::HGT_W-1:0]   fhgt_r [0:FDIV_N];
  logic [hbs_pkg::INT_W-1:0]   frx_r  [0:FDIV_N];
  logic [hbs_pkg::INT_W-1:0]   fry_r  [0:FDIV_N];
  logic [FDIV_N-1:0]           fqx_r  [0:FDIV_N];
  logic [FDIV_N-1:0]           fqy_r  [0:FDIV_N];
  logic [hbs_pkg::FRAC_BITS-1:0] ffx_r [0:FDIV_N];
  logic [hbs_pkg::FRAC_BITS-1:0] ffy_r [0:FDIV_N];
  logic                        fkill_r [1:FDIV_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= FDIV_N; j++) begin
        fv_r[j] <= 1'b0;
      end
    end else begin
      fv_r[0] <= start;
      for (int j = 1; j <= FDIV_N; j++) begin
        fv_r[j] <= fv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    fop_r[0]  <= in_item.op;
    fcol_r[0] <= in_item.grid_col;
    frow_r[0] <= in_item.grid_row;
    fhgt_r[0] <= in_item.sample_height;
    frx_r[0]  <= in_item.query_x[hbs_pkg::POS_W-1:hbs_pkg::FRAC_BITS];
    fry_r[0]  <= in_item.query_y[hbs_pkg::POS_W-1:hbs_pkg::FRAC_BITS];
    ffx_r[0]  <= in_item.query_x[hbs_pkg::FRAC_BITS-1:0];
    ffy_r[0]  <= in_item.query_y[hbs_pkg::FRAC_BITS-1:0];
    fqx_r[0]  <= '0;
    fqy_r[0]  <= '0;
    // zero spacing or position past the max_cell limit: answer zero, no flag
    fkill_r[1] <= (scale_r == '0) ||
                  ({frx_r[0], ffx_r[0]} > limit_r) ||
                  ({fry_r[0], ffy_r[0]} > limit_r);
    for (int j = 2; j <= FDIV_N; j++) begin
      fkill_r[j] <= fkill_r[j-1];
    end
    for (int j = 1; j <= FDIV_N; j++) begin
      fop_r[j]  <= fop_r[j-1];
      fcol_r[j] <= fcol_r[j-1];
      frow_r[j] <= frow_r[j-1];
      fhgt_r[j] <= fhgt_r[j-1];
      ffx_r[j]  <= ffx_r[j-1];
      ffy_r[j]  <= ffy_r[j-1];
      frx_r[j]  <= (frx_r[j-1] >= (15'(scale_r) << (FDIV_N - j)))
                   ? frx_r[j-1] - (15'(scale_r) << (FDIV_N - j)) : frx_r[j-1];
      fry_r[j]  <= (fry_r[j-1] >= (15'(scale_r) << (FDIV_N - j)))
                   ? fry_r[j-1] - (15'(scale_r) << (FDIV_N - j)) : fry_r[j-1];
      fqx_r[j]  <= {fqx_r[j-1][FDIV_N-2:0], (frx_r[j-1] >= (15'(scale_r) << (FDIV_N - j)))};
      fqy_r[j]  <= {fqy_r[j-1][FDIV_N-2:0], (fry_r[j-1] >= (15'(scale_r) << (FDIV_N - j)))};
    end
  end

  // ---------------------------------------------------------------------------
  // Bank access: reads for queries, the single write for write requests.
  // Bank b holds the points with column parity b[0] and row parity b[1].
  // ---------------------------------------------------------------------------
  logic [7:0]     bcol [4];
  logic [7:0]     brow [4];
  logic [BAW-1:0] raddr [4];
  logic [3:0]     bank_we;
  logic [BAW-1:0] waddr;
  logic           wr_ok;
  logic [15:0]    ram_rd [4];

  always_comb begin
    wr_ok = fv_r[FDIV_N] && (fop_r[FDIV_N] == hbs_pkg::OP_WRITE) &&
            (12'(fcol_r[FDIV_N]) < 12'(GRID_DIM)) &&
            (12'(frow_r[FDIV_N]) < 12'(GRID_DIM));
    waddr = BAW'(32'(frow_r[FDIV_N][6:1]) * HALF + 32'(fcol_r[FDIV_N][6:1]));
    for (int b = 0; b < 4; b++) begin
      bcol[b]    = (fqx_r[FDIV_N][0] == 1'(b)) ? {1'b0, fqx_r[FDIV_N]}
                                               : {1'b0, fqx_r[FDIV_N]} + 8'd1;
      brow[b]    = (fqy_r[FDIV_N][0] == 1'(b >> 1)) ? {1'b0, fqy_r[FDIV_N]}
                                                    : {1'b0, fqy_r[FDIV_N]} + 8'd1;
      raddr[b]   = BAW'(32'(brow[b][7:1]) * HALF + 32'(bcol[b][7:1]));
      bank_we[b] = wr_ok && (fcol_r[FDIV_N][0] == 1'(b)) &&
                   (frow_r[FDIV_N][0] == 1'(b >> 1));
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    hbs_ram #(
      .WIDTH (hbs_pkg::HGT_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (waddr),
      .wdata (fhgt_r[FDIV_N]),
      .raddr (raddr[b]),
      .rdata (ram_rd[b])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage B: fractional offsets inside the cell and the grid edge check
  // ---------------------------------------------------------------------------
  logic        bv_r, bzero_r, boor_r, bix0_r, biy0_r;
  logic [15:0] bfx_r, bgx_r, bfy_r, bgy_r;
  logic        edge_hit;
  logic [15:0] span;
  logic [15:0] fx_nxt, fy_nxt;

  always_comb begin
    span     = {scale_r, {hbs_pkg::FRAC_BITS{1'b0}}};
    fx_nxt   = {frx_r[FDIV_N][7:0], ffx_r[FDIV_N]};
    fy_nxt   = {fry_r[FDIV_N][7:0], ffy_r[FDIV_N]};
    edge_hit = (12'(fqx_r[FDIV_N]) + 12'd1 >= 12'(GRID_DIM)) ||
               (12'(fqy_r[FDIV_N]) + 12'd1 >= 12'(GRID_DIM));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= 1'b0;
    end else begin
      bv_r <= fv_r[FDIV_N] && (fop_r[FDIV_N] == hbs_pkg::OP_QUERY);
    end
    bzero_r <= fkill_r[FDIV_N] || edge_hit;
    boor_r  <= !fkill_r[FDIV_N] && edge_hit;
    bix0_r  <= fqx_r[FDIV_N][0];
    biy0_r  <= fqy_r[FDIV_N][0];
    bfx_r   <= fx_nxt;
    bfy_r   <= fy_nxt;
    bgx_r   <= span - fx_nxt;
    bgy_r   <= span - fy_nxt;
  end

  // ---------------------------------------------------------------------------
  // Stage C: corner weights; bank data steered to corners
  // corner order: (ix,iy) (ix+1,iy) (ix,iy+1) (ix+1,iy+1)
  // ---------------------------------------------------------------------------
  logic        cv_r, czero_r, coor_r;
  logic [15:0] ch_r [4];
  logic [31:0] cw_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else begin
      cv_r <= bv_r;
    end
    czero_r <= bzero_r;
    coor_r  <= boor_r;
    ch_r[0] <= ram_rd[{biy0_r, bix0_r}];
    ch_r[1] <= ram_rd[{biy0_r, ~bix0_r}];
    ch_r[2] <= ram_rd[{~biy0_r, bix0_r}];
    ch_r[3] <= ram_rd[{~biy0_r, ~bix0_r}];
    cw_r[0] <= 32'(bgx_r) * 32'(bgy_r);
    cw_r[1] <= 32'(bfx_r) * 32'(bgy_r);
    cw_r[2] <= 32'(bgx_r) * 32'(bfy_r);
    cw_r[3] <= 32'(bfx_r) * 32'(bfy_r);
  end

  // ---------------------------------------------------------------------------
  // Stage P: height x weight; stages E and S: two-level adder tree
  // ---------------------------------------------------------------------------
  logic               pv_r, pzero_r, poor_r;
  logic signed [47:0] pp_r [4];
  logic               ev_r, ezero_r, eoor_r;
  logic signed [48:0] es01_r, es23_r;
  logic               sv_r, szero_r, soor_r;
  logic signed [49:0] ssum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      ev_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      pv_r <= cv_r;
      ev_r <= pv_r;
      sv_r <= ev_r;
    end
    pzero_r <= czero_r;
    poor_r  <= coor_r;
    for (int i = 0; i < 4; i++) begin
      pp_r[i] <= 48'($signed(ch_r[i]) * $signed({1'b0, cw_r[i]}));
    end
    ezero_r <= pzero_r;
    eoor_r  <= poor_r;
    es01_r  <= 49'(pp_r[0]) + 49'(pp_r[1]);
    es23_r  <= 49'(pp_r[2]) + 49'(pp_r[3]);
    szero_r <= ezero_r;
    soor_r  <= eoor_r;
    ssum_r  <= 50'(es01_r) + 50'(es23_r);
  end

  // ---------------------------------------------------------------------------
  // Back divide: |sum| / (spacing^2 << FRAC_BITS), restoring, one bit a stage.
  // Quotient fits 24 bits since |sum| <= 2^15 * spacing^2 * 2^16.
  // Index 0 holds the magnitude split into high remainder and low bits.
  // ---------------------------------------------------------------------------
  logic        qv_r    [0:QDIV_N];
  logic        qzero_r [0:QDIV_N];
  logic        qoor_r  [0:QDIV_N];
  logic        qneg_r  [0:QDIV_N];
  logic [23:0] qrem_r  [0:QDIV_N];
  logic [23:0] qnum_r  [0:QDIV_N];
  logic [23:0] qquo_r  [0:QDIV_N];
  logic [24:0] qtrial  [1:QDIV_N];
  logic        qge     [1:QDIV_N];
  logic [49:0] sabs;

  always_comb begin
    sabs = ssum_r[49] ? 50'(-ssum_r) : 50'(ssum_r);
    for (int j = 1; j <= QDIV_N; j++) begin
      qtrial[j] = {qrem_r[j-1], qnum_r[j-1][23]};
      qge[j]    = qtrial[j] >= {1'b0, dvs_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QDIV_N; j++) begin
        qv_r[j] <= 1'b0;
      end
    end else begin
      qv_r[0] <= sv_r;
      for (int j = 1; j <= QDIV_N; j++) begin
        qv_r[j] <= qv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    qzero_r[0] <= szero_r;
    qoor_r[0]  <= soor_r;
    qneg_r[0]  <= ssum_r[49];
    qrem_r[0]  <= sabs[47:24];
    qnum_r[0]  <= sabs[23:0];
    qquo_r[0]  <= '0;
    for (int j = 1; j <= QDIV_N; j++) begin
      qzero_r[j] <= qzero_r[j-1];
      qoor_r[j]  <= qoor_r[j-1];
      qneg_r[j]  <= qneg_r[j-1];
      qrem_r[j]  <= qge[j] ? 24'(qtrial[j] - {1'b0, dvs_r}) : qtrial[j][23:0];
      qnum_r[j]  <= {qnum_r[j-1][22:0], 1'b0};
      qquo_r[j]  <= {qquo_r[j-1][22:0], qge[j]};
    end
  end

  // ---------------------------------------------------------------------------
  // Output: apply sign (truncation toward zero), saturate, zero the special
  // cases, then register the result and strobe.
  // ---------------------------------------------------------------------------
  logic [23:0] res_nxt;
  logic [23:0] quo;
  logic        out_strobe_r;
  hbs_pkg::out_item_t out_item_r;

  always_comb begin
    quo = qquo_r[QDIV_N];
    if (qzero_r[QDIV_N]) begin
      res_nxt = '0;
    end else if (qneg_r[QDIV_N]) begin
      res_nxt = (quo > 24'h800000) ? 24'h800000 : 24'(-quo);
    end else begin
      res_nxt = (quo > 24'h7FFFFF) ? 24'h7FFFFF : quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= qv_r[QDIV_N];
    end
    out_item_r.height_out   <= res_nxt;
    out_item_r.out_of_range <= qoor_r[QDIV_N];
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // every accepted query yields a result after the fixed latency
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.op == hbs_pkg::OP_QUERY)) |-> ##LAT out_strobe)
    else $error("query without result");

  // every result stems from an earlier accepted query
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && (in_item.op == hbs_pkg::OP_QUERY), LAT))
    else $error("result without query");

  // an edge hit reports zero height
  a_edge_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.out_of_range) |-> (out_item.height_out == '0))
    else $error("flagged result with non-zero height");

endmodule

`default_nettype wire
